// ===== hw/rtl/mtlt_pkg.sv =====
// mtlt_pkg: shared types and constants for the motion triggered layer timer
// payload structs of both channels, configuration block and the internal command
// no dependencies
package mtlt_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_MIN_IDLE   = 3'd0;
    localparam logic [2:0] REG_EXCL_COUNT = 3'd1;
    localparam logic [2:0] REG_EXCL_POS_A = 3'd2;
    localparam logic [2:0] REG_EXCL_POS_B = 3'd3;
    localparam logic [2:0] REG_EXCL_POS_C = 3'd4;
    localparam logic [2:0] REG_EXCL_POS_D = 3'd5;

    // input action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_MOTION = 2'd1;
    localparam logic [1:0] ACT_KEY    = 2'd2;

    localparam int EXCL_SLOTS  = 4;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = 2;
    localparam int FIFO_CW     = 3;
    localparam logic [14:0] IDLE_MAX = 15'h7fff;
    localparam logic [31:0] DIST_MAX = 32'h7fff_ffff;

    typedef struct packed {
        logic [1:0]         action;
        logic [7:0]         layer_index;
        logic signed [15:0] timeout_ms;
        logic signed [31:0] activation_level;
        logic signed [15:0] motion_value;
        logic [7:0]         key_position;
        logic               key_pressed;
    } in_item_t;

    typedef struct packed {
        logic [3:0] out_layer;
        logic       turn_on;
        logic       last_notice;
    } out_item_t;

    typedef struct packed {
        logic [14:0]                     min_idle_ms;
        logic [2:0]                      excluded_count;
        logic [EXCL_SLOTS-1:0][7:0]      excluded_pos;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_MOTION,
        CMD_PRESS
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         layer;
        logic signed [15:0] timeout;
        logic signed [31:0] level;
        logic [16:0]        mag;
    } cmd_t;

endpackage

// ===== hw/rtl/motion_triggered_layer_timer.sv =====
// motion_triggered_layer_timer: top level with configuration registers
// instantiates mtlt_front, mtlt_fifo and mtlt_exec; depends on mtlt_pkg
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes ticks, motion events and
//   key events. Output channel (out_valid / out_stall / out_item) delivers layer
//   on/off notices, the final one of each item flagged by last_notice.
//   Configuration writes (cfg_valid / cfg_ready / cfg_index / cfg_data) are taken
//   every cycle; write only while no item is in flight.
//   The front end classifies an item in the accept cycle and queues it (four
//   commands deep); items that cannot change anything are dropped there.
//   The back end applies one command per cycle (a tick or key press to all layers,
//   a motion to one), then sends its notices one per cycle in ascending layer order
//   unless the output stalls, popping no command meanwhile. An accepted item passes
//   the queue, the mask and state registers and the output register to out_valid.
//   A stalled output holds its notice and pauses the notice sequence; the queue
//   keeps accepting until full, then in_stall rises.
//   Reset clears all layer state, the idle count and all registers but queue storage to zero.
module motion_triggered_layer_timer
    import mtlt_pkg::*;
#(
    parameter int LAYER_COUNT  = 16,
    parameter int EXCLUDED_MAX = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [14:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic fifo_full;
    logic push;
    cmd_t push_cmd;
    logic pop;
    logic not_empty;
    cmd_t head;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIN_IDLE:   cfg_next.min_idle_ms     = cfg_data;
                REG_EXCL_COUNT: cfg_next.excluded_count  = cfg_data[2:0];
                REG_EXCL_POS_A: cfg_next.excluded_pos[0] = cfg_data[7:0];
                REG_EXCL_POS_B: cfg_next.excluded_pos[1] = cfg_data[7:0];
                REG_EXCL_POS_C: cfg_next.excluded_pos[2] = cfg_data[7:0];
                REG_EXCL_POS_D: cfg_next.excluded_pos[3] = cfg_data[7:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg_ready = 1'b1;

    mtlt_front #(
        .LAYER_COUNT  (LAYER_COUNT),
        .EXCLUDED_MAX (EXCLUDED_MAX)
    ) u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .cfg       (cfg_reg),
        .fifo_full (fifo_full),
        .push      (push),
        .cmd       (push_cmd)
    );

    mtlt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (fifo_full),
        .pop       (pop),
        .not_empty (not_empty),
        .head      (head)
    );

    mtlt_exec #(
        .LAYER_COUNT (LAYER_COUNT)
    ) u_exec (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (not_empty),
        .cmd       (head),
        .cmd_pop   (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

// ===== hw/rtl/mtlt_front.sv =====
// mtlt_front: accepts input transactions and turns them into back-end commands
// drops items that change nothing; depends on mtlt_pkg
module mtlt_front
    import mtlt_pkg::*;
#(
    parameter int LAYER_COUNT  = 16,
    parameter int EXCLUDED_MAX = 4
)
(
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  cfg_t     cfg,
    input  logic     fifo_full,
    output logic     push,
    output cmd_t     cmd
);

    logic [2:0] excl_used;
    logic       excluded;
    logic       keep;

    // clamp the excluded count and compare the key position
    always_comb
    begin
        excl_used = (cfg.excluded_count > 3'(EXCLUDED_MAX)) ? 3'(EXCLUDED_MAX)
                                                            : cfg.excluded_count;
        excluded = 1'b0;
        for (int k = 0; k < EXCLUDED_MAX; k++)
        begin
            if ((3'(k) < excl_used) && (cfg.excluded_pos[k] == in_item.key_position))
                excluded = 1'b1;
        end
    end

    // classify the item
    always_comb
    begin
        cmd.kind    = CMD_TICK;
        cmd.layer   = in_item.layer_index;
        cmd.timeout = in_item.timeout_ms;
        cmd.level   = in_item.activation_level;
        cmd.mag     = in_item.motion_value[15]
                    ? 17'(-{in_item.motion_value[15], in_item.motion_value})
                    : {1'b0, in_item.motion_value};
        keep = 1'b0;
        unique case (in_item.action)
            ACT_TICK:
            begin
                cmd.kind = CMD_TICK;
                keep     = 1'b1;
            end
            ACT_MOTION:
            begin
                cmd.kind = CMD_MOTION;
                keep     = (9'(in_item.layer_index) < 9'(LAYER_COUNT));
            end
            ACT_KEY:
            begin
                cmd.kind = CMD_PRESS;
                keep     = in_item.key_pressed && !excluded;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign in_stall = fifo_full;
    assign push     = in_valid && !fifo_full && keep;

endmodule

// ===== hw/rtl/mtlt_fifo.sv =====
// mtlt_fifo: short command queue between front and back end
// show-ahead read; depends on mtlt_pkg
module mtlt_fifo
    import mtlt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    cmd_t                 store [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_cmd;
    end

    assign full      = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = store[rd_ptr_reg];

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command popped from empty queue");
`endif

endmodule

// ===== hw/rtl/mtlt_exec.sv =====
// mtlt_exec: back end holding per-layer state, applying commands and
// emitting layer notices through an output register; depends on mtlt_pkg
module mtlt_exec
    import mtlt_pkg::*;
#(
    parameter int LAYER_COUNT = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [LAYER_COUNT-1:0] on_reg, on_next;
    logic [31:0]            dist_reg [LAYER_COUNT];
    logic [31:0]            dist_next [LAYER_COUNT];
    logic [14:0]            cd_reg [LAYER_COUNT];
    logic [14:0]            cd_next [LAYER_COUNT];
    logic [14:0]            ms_reg, ms_next;
    logic [LAYER_COUNT-1:0] mask_reg, mask_next;
    logic                   dir_reg, dir_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_item_reg, out_item_next;

    logic [LW-1:0]          lidx;
    logic [32:0]            raw_sum;
    logic [31:0]            new_sum;
    logic                   reached;
    logic                   gated;
    logic                   tmo_pos;
    logic [LAYER_COUNT-1:0] low_bit;
    logic [LAYER_COUNT-1:0] mask_rest;
    logic [LW-1:0]          low_idx;
    logic                   out_load;

    // motion datapath: saturating accumulate and signed compare
    always_comb
    begin
        lidx    = cmd.layer[LW-1:0];
        raw_sum = {1'b0, dist_reg[lidx]} + {16'b0, cmd.mag};
        new_sum = (raw_sum > {1'b0, DIST_MAX}) ? DIST_MAX : raw_sum[31:0];
        reached = $signed({1'b0, new_sum}) >= $signed({cmd.level[31], cmd.level});
        gated   = !on_reg[lidx] && (cfg.min_idle_ms != '0) && (ms_reg < cfg.min_idle_ms);
        tmo_pos = !cmd.timeout[15] && (cmd.timeout != '0);
    end

    // lowest pending notice
    always_comb
    begin
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        mask_rest = mask_reg & ~low_bit;
        low_idx   = '0;
        for (int i = 0; i < LAYER_COUNT; i++)
        begin
            if (low_bit[i])
                low_idx = low_idx | LW'(i);
        end
    end

    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;

    // next state of layers, sequencer and output register
    always_comb
    begin
        state_next    = state_reg;
        on_next       = on_reg;
        dist_next     = dist_reg;
        cd_next       = cd_reg;
        ms_next       = ms_reg;
        mask_next     = mask_reg;
        dir_next      = dir_reg;
        out_item_next = out_item_reg;
        out_valid_next = out_stall ? out_valid_reg : 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    mask_next = '0;
                    dir_next  = 1'b0;
                    unique case (cmd.kind)
                        CMD_TICK:
                        begin
                            if (ms_reg != IDLE_MAX)
                                ms_next = ms_reg + 1'b1;
                            for (int i = 0; i < LAYER_COUNT; i++)
                            begin
                                if (cd_reg[i] != '0)
                                begin
                                    cd_next[i] = cd_reg[i] - 1'b1;
                                    if ((cd_reg[i] == 15'd1) && on_reg[i])
                                    begin
                                        on_next[i]   = 1'b0;
                                        dist_next[i] = '0;
                                        mask_next[i] = 1'b1;
                                    end
                                end
                            end
                        end
                        CMD_MOTION:
                        begin
                            if (!gated)
                            begin
                                if (!on_reg[lidx])
                                begin
                                    dist_next[lidx] = new_sum;
                                    if (reached)
                                    begin
                                        on_next[lidx]   = 1'b1;
                                        mask_next[lidx] = 1'b1;
                                        dir_next        = 1'b1;
                                    end
                                end
                                if ((on_reg[lidx] || reached) && tmo_pos)
                                    cd_next[lidx] = cmd.timeout[14:0];
                            end
                        end
                        CMD_PRESS:
                        begin
                            ms_next = '0;
                            for (int i = 0; i < LAYER_COUNT; i++)
                            begin
                                if (on_reg[i])
                                begin
                                    on_next[i]   = 1'b0;
                                    dist_next[i] = '0;
                                    cd_next[i]   = '0;
                                    mask_next[i] = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            mask_next = '0;
                        end
                    endcase
                    if (mask_next != '0)
                        state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.out_layer   = 4'(low_idx);
                    out_item_next.turn_on     = dir_reg;
                    out_item_next.last_notice = (mask_rest == '0);
                    mask_next                 = mask_rest;
                    if (mask_rest == '0)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            on_reg        <= '0;
            ms_reg        <= '0;
            mask_reg      <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            for (int i = 0; i < LAYER_COUNT; i++)
            begin
                dist_reg[i] <= '0;
                cd_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            on_reg        <= on_next;
            ms_reg        <= ms_next;
            mask_reg      <= mask_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
            out_item_reg  <= out_item_next;
            dist_reg      <= dist_next;
            cd_reg        <= cd_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTH
    a_emit_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (mask_reg != '0))
        else $error("emit state with no pending notice");
    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && (mask_rest == '0)) |=> (state_reg == S_IDLE) && out_item.last_notice)
        else $error("final notice did not close the run");
    a_motion_single: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && (cmd.kind == CMD_MOTION)) |=> ($countones(mask_reg) <= 1))
        else $error("motion produced more than one notice");
`endif

endmodule
